>>> hdl/ucd_pkg.sv
// Shared types, constants and helper functions of the UTF-8 code point decoder.
package ucd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned USED_W = 3;

    localparam logic [CP_W-1:0]   REPL_CHAR  = 21'h00003F;
    localparam logic [CP_W-1:0]   MAX_SCALAR = 21'h10FFFF;

    // Lowest two-byte lead, and leads that need an extra range check on the second byte.
    localparam logic [BYTE_W-1:0] LEAD_2_MIN = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;

    // Second-byte limits for those leads.
    localparam logic [BYTE_W-1:0] E0_TAIL_MIN = 8'hA0;
    localparam logic [BYTE_W-1:0] ED_TAIL_MAX = 8'h9F;
    localparam logic [BYTE_W-1:0] F0_TAIL_MIN = 8'h90;
    localparam logic [BYTE_W-1:0] F4_TAIL_MAX = 8'h8F;

    // Byte counts reported in bytes_used.
    localparam logic [USED_W-1:0] USED_ONE   = 3'd1;
    localparam logic [USED_W-1:0] USED_TWO   = 3'd2;
    localparam logic [USED_W-1:0] USED_THREE = 3'd3;
    localparam logic [USED_W-1:0] USED_FOUR  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] third_byte;
        logic [BYTE_W-1:0] fourth_byte;
    } in_word_t;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [USED_W-1:0] bytes_used;
    } out_word_t;

    // A continuation byte has the form 10xxxxxx; a zero byte never qualifies.
    function automatic logic is_tail(input logic [BYTE_W-1:0] b);
        is_tail = (b[7:6] == 2'b10);
    endfunction

endpackage

>>> hdl/utf8_codepoint_decoder_unit.sv
// Top level of the UTF-8 code point decoder: input register, decode, result register.
//
// Usage: the sender presents a four-byte window of text on s_word, starting at the
// current text position, and raises s_valid. A word is taken at a rising edge of aclk
// where s_valid and s_ready are both high. Each window yields exactly one result word
// on m_word: the decoded code point (or 0x3F for a malformed sequence) and the number
// of bytes the sender should advance before forming its next window.
// An accepted word waits in the input register and moves on into the result register
// whenever that register is free, which sets m_valid; the receiver takes it while
// m_ready is high. Throughput: one word per cycle while m_ready stays high. The path
// between the input register and the result register is a single pass of lead-byte
// classification, tail checks and field packing.
// When the receiver holds m_ready low, the result register keeps its word and the input
// register can still take one more word; only when both are full does s_ready drop.
// s_ready follows m_ready combinationally through that two-entry pipeline.
// Reset (aresetn low at a clock edge) empties both registers; no result is pending
// afterwards and the decoder holds no other state.
module utf8_codepoint_decoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ucd_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output ucd_pkg::out_word_t m_word
);

    logic               in_valid_reg;
    logic               in_valid_next;
    ucd_pkg::in_word_t  in_word_reg;
    ucd_pkg::in_word_t  in_word_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ucd_pkg::out_word_t out_word_reg;
    ucd_pkg::out_word_t out_word_next;
    ucd_pkg::out_word_t dec_word;
    logic               out_free;
    logic               in_free;
    logic               in_move;

    // The result register can load when it is empty or its word leaves this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // The held input word moves into the result register whenever there is room.
    assign in_move  = in_valid_reg && out_free;
    // The input register can load when it is empty or its word moves on this cycle.
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    ucd_decode u_decode (
        .in_word  (in_word_reg),
        .out_word (dec_word)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_free) begin
            in_valid_next = s_valid;
            in_word_next  = s_word;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
            out_word_next  = dec_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    // A pending window is never dropped: if it moves on, a result follows next cycle.
    a_move_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_move |=> m_valid)
        else $error("decoded word did not reach the result register");

    // Back-pressure only happens when both registers are occupied.
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low while the pipeline has room");

    // The advance count is always between one and four bytes.
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.bytes_used >= ucd_pkg::USED_ONE &&
                     m_word.bytes_used <= ucd_pkg::USED_FOUR))
        else $error("bytes_used out of range");

    // Results are Unicode scalars: no surrogates and nothing above U+10FFFF.
    a_scalar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.code_point <= ucd_pkg::MAX_SCALAR &&
                     !(m_word.code_point >= 21'h00D800 && m_word.code_point <= 21'h00DFFF)))
        else $error("code_point is not a Unicode scalar");

    // A multi-byte scalar never comes with a one-byte advance.
    a_ascii_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.code_point > 21'h00007F) |->
            (m_word.bytes_used != ucd_pkg::USED_ONE))
        else $error("non-ASCII code point reported with one byte used");

endmodule

>>> hdl/ucd_decode.sv
// Combinational decode of one UTF-8 sequence from a four-byte window.
module ucd_decode (
    input  ucd_pkg::in_word_t  in_word,
    output ucd_pkg::out_word_t out_word
);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic        t1;
    logic        t2;
    logic        t3;
    logic [20:0] cp;
    logic [2:0]  used;

    assign b0 = in_word.first_byte;
    assign b1 = in_word.second_byte;
    assign b2 = in_word.third_byte;
    assign b3 = in_word.fourth_byte;
    assign t1 = ucd_pkg::is_tail(b1);
    assign t2 = ucd_pkg::is_tail(b2);
    assign t3 = ucd_pkg::is_tail(b3);

    always_comb begin
        cp   = ucd_pkg::REPL_CHAR;
        used = ucd_pkg::USED_ONE;
        if (!b0[7]) begin
            cp = {13'd0, b0};
        end else if (b0[7:5] == 3'b110) begin
            if (!t1) begin
                used = ucd_pkg::USED_TWO;
            end else if (b0 >= ucd_pkg::LEAD_2_MIN) begin
                cp   = {10'd0, b0[4:0], b1[5:0]};
                used = ucd_pkg::USED_TWO;
            end
        end else if (b0[7:4] == 4'b1110) begin
            if (!t1) begin
                used = ucd_pkg::USED_TWO;
            end else if (!t2) begin
                used = ucd_pkg::USED_THREE;
            end else if ((b0 == ucd_pkg::LEAD_E0 && b1 < ucd_pkg::E0_TAIL_MIN) ||
                         (b0 == ucd_pkg::LEAD_ED && b1 > ucd_pkg::ED_TAIL_MAX)) begin
                used = ucd_pkg::USED_TWO;
            end else begin
                cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                used = ucd_pkg::USED_THREE;
            end
        end else if (b0[7:3] == 5'b11110) begin
            if (b0 > ucd_pkg::LEAD_F4) begin
                used = ucd_pkg::USED_ONE;
            end else if (!t1) begin
                used = ucd_pkg::USED_TWO;
            end else if (!t2) begin
                used = ucd_pkg::USED_THREE;
            end else if (!t3) begin
                used = ucd_pkg::USED_FOUR;
            end else if ((b0 == ucd_pkg::LEAD_F0 && b1 < ucd_pkg::F0_TAIL_MIN) ||
                         (b0 == ucd_pkg::LEAD_F4 && b1 > ucd_pkg::F4_TAIL_MAX)) begin
                used = ucd_pkg::USED_TWO;
            end else begin
                cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                used = ucd_pkg::USED_FOUR;
            end
        end
        // Range guard on the assembled scalar; the checks above normally keep it in range.
        if (cp > ucd_pkg::MAX_SCALAR) begin
            cp = ucd_pkg::REPL_CHAR;
        end
    end

    assign out_word.code_point = cp;
    assign out_word.bytes_used = used;

endmodule

>>> tb/tb_utf8_codepoint_decoder_unit.sv
// Self-checking testbench of the UTF-8 code point decoder: directed and random windows.
`timescale 1ns / 100ps

module tb_utf8_codepoint_decoder_unit;

    // The receiver holds m_ready low this long once during the hold-off test.
    localparam int unsigned HOLD_CYCLES  = 300;
    // The watchdog ends the run after this many cycles with no word accepted on
    // either channel. It covers the hold-off above several times over.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Idle probability of either side, in percent.
    localparam int unsigned IDLE_PERCENT = 17;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ucd_pkg::in_word_t  s_word  = '0;
    logic               m_valid;
    logic               m_ready;
    ucd_pkg::out_word_t m_word;

    // Decoded results still owed by the block, oldest first.
    ucd_pkg::out_word_t expected_cps[$];
    int unsigned        mismatch_count = 0;
    int unsigned        idle_cycles    = 0;
    // When set, neither side idles at random.
    bit                 calm           = 1'b0;
    // Set by a test to make the receiver start its long hold-off.
    bit                 hold_req       = 1'b0;

    utf8_codepoint_decoder_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #2 aclk = ~aclk;

    // A continuation byte is 10xxxxxx, which already rules out the zero byte
    // that marks the end of the text.
    function automatic bit is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Predicts the result word for one window. The checks run in a fixed order: lead
    // class, then each continuation byte in turn, then the second-byte range for the
    // leads that need one. The byte count on an error is the position of the first
    // byte that failed, or one for a bad lead (0xC0/0xC1 only with a good tail).
    function automatic ucd_pkg::out_word_t decode_window(input ucd_pkg::in_word_t w);
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [7:0]         b3;
        ucd_pkg::out_word_t r;
        b0 = w.first_byte;
        b1 = w.second_byte;
        b2 = w.third_byte;
        b3 = w.fourth_byte;
        r.code_point = ucd_pkg::REPL_CHAR;
        r.bytes_used = ucd_pkg::USED_ONE;
        if (!b0[7]) begin
            r.code_point = {13'd0, b0};
        end else if (b0[7:5] == 3'b110) begin
            // Leads 0xC0 and 0xC1 are overlong: with a good tail only the lead
            // is skipped.
            if (!is_cont(b1)) begin
                r.bytes_used = ucd_pkg::USED_TWO;
            end else if (b0 >= ucd_pkg::LEAD_2_MIN) begin
                r.code_point = {10'd0, b0[4:0], b1[5:0]};
                r.bytes_used = ucd_pkg::USED_TWO;
            end
        end else if (b0[7:4] == 4'b1110) begin
            if (!is_cont(b1)) begin
                r.bytes_used = ucd_pkg::USED_TWO;
            end else if (!is_cont(b2)) begin
                r.bytes_used = ucd_pkg::USED_THREE;
            end else if ((b0 == ucd_pkg::LEAD_E0 && b1 < ucd_pkg::E0_TAIL_MIN) ||
                         (b0 == ucd_pkg::LEAD_ED && b1 > ucd_pkg::ED_TAIL_MAX)) begin
                r.bytes_used = ucd_pkg::USED_TWO;
            end else begin
                r.code_point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                r.bytes_used = ucd_pkg::USED_THREE;
            end
        end else if (b0[7:3] == 5'b11110 && b0 <= ucd_pkg::LEAD_F4) begin
            if (!is_cont(b1)) begin
                r.bytes_used = ucd_pkg::USED_TWO;
            end else if (!is_cont(b2)) begin
                r.bytes_used = ucd_pkg::USED_THREE;
            end else if (!is_cont(b3)) begin
                r.bytes_used = ucd_pkg::USED_FOUR;
            end else if ((b0 == ucd_pkg::LEAD_F0 && b1 < ucd_pkg::F0_TAIL_MIN) ||
                         (b0 == ucd_pkg::LEAD_F4 && b1 > ucd_pkg::F4_TAIL_MAX)) begin
                r.bytes_used = ucd_pkg::USED_TWO;
            end else begin
                r.code_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                r.bytes_used = ucd_pkg::USED_FOUR;
            end
        end
        if (r.code_point > ucd_pkg::MAX_SCALAR) begin
            r.code_point = ucd_pkg::REPL_CHAR;
        end
        return r;
    endfunction

    // Builds a random window. Most windows hold a well-formed sequence with random
    // content, so that every length and every range-checked lead is decoded fully.
    // The rest are sequences with one byte clobbered (often by the end-of-text zero)
    // and plain noise. Bytes past the sequence are always random.
    function automatic ucd_pkg::in_word_t random_window();
        ucd_pkg::in_word_t w;
        int unsigned       pick;
        logic [7:0]        junk;
        w = $urandom;
        pick = $urandom_range(99);
        if (pick < 15) begin
            w.first_byte = 8'($urandom_range(8'h7F, 8'h00));
        end else if (pick < 88) begin
            w.second_byte = 8'($urandom_range(8'hBF, 8'h80));
            w.third_byte  = 8'($urandom_range(8'hBF, 8'h80));
            w.fourth_byte = 8'($urandom_range(8'hBF, 8'h80));
            if (pick < 35) begin
                w.first_byte = 8'($urandom_range(8'hDF, ucd_pkg::LEAD_2_MIN));
            end else if (pick < 55) begin
                w.first_byte = 8'($urandom_range(8'hEF, ucd_pkg::LEAD_E0));
                if (w.first_byte == ucd_pkg::LEAD_E0) begin
                    w.second_byte = 8'($urandom_range(8'hBF, ucd_pkg::E0_TAIL_MIN));
                end else if (w.first_byte == ucd_pkg::LEAD_ED) begin
                    w.second_byte = 8'($urandom_range(ucd_pkg::ED_TAIL_MAX, 8'h80));
                end
            end else if (pick < 75) begin
                w.first_byte = 8'($urandom_range(ucd_pkg::LEAD_F4, ucd_pkg::LEAD_F0));
                if (w.first_byte == ucd_pkg::LEAD_F0) begin
                    w.second_byte = 8'($urandom_range(8'hBF, ucd_pkg::F0_TAIL_MIN));
                end else if (w.first_byte == ucd_pkg::LEAD_F4) begin
                    w.second_byte = 8'($urandom_range(ucd_pkg::F4_TAIL_MAX, 8'h80));
                end
            end else begin
                // Broken sequence: any multi-byte lead, one byte replaced.
                w.first_byte = 8'($urandom_range(8'hF7, 8'hC0));
                junk = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
                case ($urandom_range(3, 1))
                    1: w.second_byte = junk;
                    2: w.third_byte  = junk;
                    default: w.fourth_byte = junk;
                endcase
            end
        end
        return w;
    endfunction

    // Offers one window and returns at the falling edge after it is taken. It is
    // entered at a falling edge, so exactly one assignment to s_valid happens per
    // edge: either the low of an idle gap or the high that carries the new word.
    // On return s_valid is still high until an idle gap or the caller lowers it.
    task automatic send_window(input ucd_pkg::in_word_t w);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until the block has handed back every result owed.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_cps.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // ASCII leads, the zero lead among them, with arbitrary trailing bytes.
    task automatic test_ascii_leads();
        send_window(32'h00_00_00_00);
        send_window(32'h41_FF_80_00);
        send_window(32'h7F_BF_BF_BF);
    endtask

    // Stray continuation bytes and leads above 0xF4 consume a single byte.
    task automatic test_invalid_leads();
        send_window(32'h80_80_80_80);
        send_window(32'hBF_BF_BF_BF);
        send_window(32'hF5_80_80_80);
        send_window(32'hFF_FF_FF_FF);
    endtask

    // Two-byte forms: both ends of the valid range, and the overlong leads with
    // a good tail and with the end-of-text zero as the tail.
    task automatic test_two_byte_forms();
        send_window(32'hC2_80_00_00);
        send_window(32'hDF_BF_FF_FF);
        send_window(32'hC0_80_41_41);
        send_window(32'hC1_00_41_41);
    endtask

    // Three-byte forms: range ends, the overlong and surrogate boundaries, and a
    // bad second and third byte.
    task automatic test_three_byte_forms();
        send_window(32'hE0_A0_80_00);
        send_window(32'hE0_9F_BF_00);
        send_window(32'hED_9F_BF_00);
        send_window(32'hED_A0_80_00);
        send_window(32'hEF_BF_BF_FF);
        send_window(32'hE1_7F_80_00);
        send_window(32'hE1_80_00_00);
    endtask

    // Four-byte forms: lowest and highest scalar, the overlong boundary, a value
    // above U+10FFFF, and a bad byte in each continuation position.
    task automatic test_four_byte_forms();
        send_window(32'hF0_90_80_80);
        send_window(32'hF0_8F_BF_BF);
        send_window(32'hF4_8F_BF_BF);
        send_window(32'hF4_90_80_80);
        send_window(32'hF1_80_80_00);
        send_window(32'hF2_80_C0_80);
        send_window(32'hF3_00_80_80);
    endtask

    task automatic test_random_text(input int unsigned count);
        repeat (count) send_window(random_window());
    endtask

    // Back-to-back words with both sides always ready.
    task automatic test_full_rate();
        calm = 1'b1;
        repeat (60) send_window(random_window());
        calm = 1'b0;
    endtask

    // The receiver stalls for a long stretch while words keep coming, so both
    // pipeline registers fill and s_ready drops until the stall ends.
    task automatic test_output_hold_off();
        hold_req = 1'b1;
        repeat (40) send_window(random_window());
    endtask

    // The sender stops with words in flight and resumes only once all are back.
    task automatic test_drain_pause();
        repeat (20) send_window(random_window());
        wait_for_drain();
        repeat (20) send_window(random_window());
    endtask

    // Receiver: m_ready changes at the falling edge. A hold-off request keeps it
    // low for a long stretch, counted out here.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Monitor at the rising edge: every accepted window adds a prediction, and
    // every accepted result is checked against the oldest one. Pushing before
    // popping is safe since a result never comes out at its window's own edge.
    always @(posedge aclk) begin : monitor
        ucd_pkg::out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_cps.push_back(decode_window(s_word));
            end
            if (m_valid && m_ready) begin
                if (expected_cps.size() == 0) begin
                    $display("%0t: expected no word, got code_point %h bytes_used %0d",
                             $time, m_word.code_point, m_word.bytes_used);
                    mismatch_count++;
                end else begin
                    want = expected_cps.pop_front();
                    if (m_word.code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h, got %h",
                                 $time, want.code_point, m_word.code_point);
                        mismatch_count++;
                    end
                    if (m_word.bytes_used !== want.bytes_used) begin
                        $display("%0t: bytes_used expected %0d, got %0d",
                                 $time, want.bytes_used, m_word.bytes_used);
                        mismatch_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog: a run that stops moving words is a failure.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge aclk);
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_ascii_leads();
        test_invalid_leads();
        test_two_byte_forms();
        test_three_byte_forms();
        test_four_byte_forms();
        test_random_text(200);
        test_full_rate();
        test_output_hold_off();
        test_drain_pause();
        test_random_text(200);

        // Let the last results out, then give the block a few more edges so a
        // stray extra word would still be caught.
        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_cps.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
